### hdl/quad_motor_mixer_pwm_core_assert.svh
// assertion macros for the motor mixer
`ifndef QUAD_MOTOR_MIXER_PWM_CORE_ASSERT_SVH
`define QUAD_MOTOR_MIXER_PWM_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define QMM_ASSERT_IMP(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define QMM_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);
`endif

### hdl/qmm_pkg.sv
// shared types and constants for the motor mixer
package qmm_pkg;
	typedef enum logic [2:0] {
		REG_LOW   = 3'd0,
		REG_HIGH  = 3'd1,
		REG_CAP   = 3'd2,
		REG_ARM_L = 3'd3,
		REG_ARM_W = 3'd4
	} reg_idx_t;
	localparam logic [19:0] K_A = 20'd136533;
	localparam logic [19:0] K_B = 20'd126031;
	localparam logic [19:0] K_C = 20'd455111;
	localparam logic [19:0] K_D = 20'd17644;
	localparam logic [19:0] K_E = 20'd117029;
	localparam logic [19:0] K_F = 20'd390095;
	localparam logic [19:0] K_G = 20'd15124;
	typedef struct packed {
		logic start;
		logic halt;
	} qmm_cmd_t;
	typedef struct packed {
		logic done;
	} qmm_sts_t;
endpackage

### hdl/qmm_stream_if.sv
// valid/ready channel interfaces
interface qmm_in_if #(parameter int W = 16);
	logic valid;
	logic ready;
	logic signed [W-1:0] force_x;
	logic signed [W-1:0] force_y;
	logic signed [W-1:0] force_z;
	logic signed [W-1:0] yaw_cmd;
	logic kill_line;
	modport source (output valid, force_x, force_y, force_z, yaw_cmd, kill_line, input ready);
	modport sink (input valid, force_x, force_y, force_z, yaw_cmd, kill_line, output ready);
endinterface

interface qmm_out_if;
	logic valid;
	logic ready;
	logic [11:0] pulse_rear_right;
	logic [11:0] pulse_front_right;
	logic [11:0] pulse_rear_left;
	logic [11:0] pulse_front_left;
	logic halted;
	modport source (output valid, pulse_rear_right, pulse_front_right, pulse_rear_left,
		pulse_front_left, halted, input ready);
	modport sink (input valid, pulse_rear_right, pulse_front_right, pulse_rear_left,
		pulse_front_left, halted, output ready);
endinterface

interface qmm_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/qmm_datapath.sv
// iterative mixer datapath: square root, shared multiplier, divide by five, pulse map
module qmm_datapath import qmm_pkg::*; #(
	parameter int W = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  qmm_cmd_t cmd,
	output qmm_sts_t sts,
	input  logic signed [W-1:0] fx_i,
	input  logic signed [W-1:0] fy_i,
	input  logic signed [W-1:0] fz_i,
	input  logic signed [W-1:0] yw_i,
	input  logic [11:0] low_q,
	input  logic [11:0] high_q,
	input  logic [11:0] cap_q,
	input  logic [15:0] arml_q,
	input  logic [15:0] armw_q,
	output logic [11:0] p_rr,
	output logic [11:0] p_fr,
	output logic [11:0] p_rl,
	output logic [11:0] p_fl
);
	localparam int SQW = 2*W + 2;
	localparam int RW = W + 1;
	localparam int TW = W + 18;
	localparam int AW = TW + 24;
	localparam int NSQ = (SQW + 1) / 2;
	localparam int MA = (TW > 37 ? TW : 37) + 1;
	localparam int MB = 21;
	localparam int ND = (AW + 15) / 16;
	localparam int DPW = 16 * ND;
	localparam logic [19:0] RECIP5 = 20'd838861;
	localparam logic [36:0] THR_SAT = 37'h10_0000_0000;

	typedef enum logic [3:0] {
		PH_IDLE, PH_SQ, PH_SQRT, PH_TRQ, PH_MIX, PH_DIV, PH_MAP, PH_DONE
	} ph_t;
	ph_t ph_q;
	logic [5:0] cnt_q;

	logic signed [MA-1:0] ma;
	logic signed [MB-1:0] mb;
	logic signed [MA+MB-1:0] mp;
	assign mp = ma * mb;

	logic signed [W-1:0] fx_q, fy_q, fz_q, yw_q;
	logic [SQW-1:0] sq_q, rem_q;
	logic [RW-1:0] root_q;
	logic signed [TW-1:0] tx_q, ty_q;
	logic signed [AW-1:0] acc_q [4];
	logic [36:0] thr_q [4];
	logic [11:0] pls_q [4];
	logic [1:0] mot;
	logic [1:0] mot_cnt_q;

	// sqrt one result bit per cycle
	logic [RW+1:0] trial;
	logic [SQW+1:0] remx;
	assign remx = {rem_q, sq_q[SQW-1 -: 2]};
	assign trial = {root_q, 2'b01};

	logic signed [TW-1:0] tq;
	assign tq = TW'(mp >>> 8);

	// coefficient selection per motor/term
	logic [19:0] kc;
	logic neg;
	logic signed [TW-1:0] tsel;
	always_comb begin
		mot = cnt_q[3:2];
		kc = K_D; neg = 1'b0; tsel = '0;
		case (cnt_q[1:0])
			2'd0: begin
				tsel = tx_q;
				kc = (mot == 2'd1 || mot == 2'd3) ? K_A : K_E;
				neg = (mot == 2'd0 || mot == 2'd1);
			end
			2'd1: begin
				tsel = ty_q; kc = K_B;
				neg = (mot == 2'd0 || mot == 2'd2);
			end
			2'd2: begin
				tsel = TW'(yw_q);
				kc = (mot == 2'd1 || mot == 2'd3) ? K_C : K_F;
				neg = (mot == 2'd1 || mot == 2'd2);
			end
			default: begin
				tsel = TW'(signed'({1'b0, root_q}));
				kc = (mot == 2'd1 || mot == 2'd3) ? K_D : K_G;
				neg = 1'b0;
			end
		endcase
	end

	// thr -> pulse mapping
	logic signed [12:0] span;
	assign span = $signed({1'b0, high_q}) - $signed({1'b0, low_q});
	logic signed [MA+MB-1:0] pnum;
	logic signed [MA+MB-1:0] pq;
	assign pnum = mp + ($signed({{(MA+MB-12){1'b0}}, low_q}) <<< 24);
	assign pq = (pnum < 0) ? -((-pnum) >>> 24) : (pnum >>> 24);

	// divide by five on magnitude: one 16-bit digit per cycle by reciprocal multiply
	logic [DPW-1:0] dmag_q, dq_q;
	logic [2:0] drem_q;
	logic dneg_q;
	logic [18:0] dv;
	logic [38:0] dprod;
	logic [15:0] dqd;
	logic [18:0] dq5;
	logic [18:0] ddiff;
	assign dv = {drem_q, dmag_q[DPW-1 -: 16]};
	assign dprod = dv * RECIP5;
	assign dqd = dprod[37:22];
	assign dq5 = {1'b0, dqd, 2'b00} + {3'b000, dqd};
	assign ddiff = dv - dq5;

	always_comb begin
		ma = '0; mb = '0;
		case (ph_q)
			PH_SQ: begin
				case (cnt_q[1:0])
					2'd0: begin ma = MA'(fx_q); mb = MB'(fx_q); end
					2'd1: begin ma = MA'(fy_q); mb = MB'(fy_q); end
					default: begin ma = MA'(fz_q); mb = MB'(fz_q); end
				endcase
			end
			PH_TRQ: begin
				if (cnt_q[0] == 1'b0) begin
					ma = MA'(fy_q); mb = MB'(signed'({1'b0, arml_q}));
				end else begin
					ma = -MA'(fx_q); mb = MB'(signed'({1'b0, armw_q}));
				end
			end
			PH_MIX: begin ma = MA'(tsel); mb = MB'(signed'({1'b0, kc})); end
			PH_MAP: begin
				ma = MA'(signed'({1'b0, thr_q[cnt_q[1:0]]}));
				mb = MB'(span);
			end
			default: ;
		endcase
	end

	logic signed [MA+MB-1:0] pclip;
	always_comb begin
		pclip = pq;
		if (pclip > $signed({{(MA+MB-12){1'b0}}, cap_q})) pclip = {{(MA+MB-12){1'b0}}, cap_q};
		if (pclip < 0) pclip = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			cnt_q <= '0;
		end else begin
			case (ph_q)
				PH_IDLE: if (cmd.start) begin
					fx_q <= fx_i; fy_q <= fy_i; fz_q <= fz_i; yw_q <= yw_i;
					sq_q <= '0; cnt_q <= '0;
					ph_q <= cmd.halt ? PH_DONE : PH_SQ;
				end
				PH_SQ: begin
					sq_q <= sq_q + SQW'(unsigned'(mp));
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd2) begin
						cnt_q <= '0; rem_q <= '0; root_q <= '0; ph_q <= PH_SQRT;
					end
				end
				PH_SQRT: begin
					sq_q <= sq_q << 2;
					if (remx >= (SQW+2)'(trial)) begin
						rem_q <= SQW'(remx - (SQW+2)'(trial));
						root_q <= {root_q[RW-2:0], 1'b1};
					end else begin
						rem_q <= SQW'(remx);
						root_q <= {root_q[RW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(NSQ-1)) begin cnt_q <= '0; ph_q <= PH_TRQ; end
				end
				PH_TRQ: begin
					if (cnt_q[0] == 1'b0) tx_q <= tq; else ty_q <= tq;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[0]) begin
						cnt_q <= '0;
						for (int i = 0; i < 4; i++) acc_q[i] <= '0;
						ph_q <= PH_MIX;
					end
				end
				PH_MIX: begin
					acc_q[mot] <= neg ? acc_q[mot] - AW'(mp) : acc_q[mot] + AW'(mp);
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd15) begin
						cnt_q <= '0; ph_q <= PH_DIV;
						dneg_q <= acc_q[0][AW-1] ^ 1'b0;
					end
				end
				PH_DIV: begin
					// per motor: load, ND digit steps, store
					if (cnt_q == 6'd0) begin
						dmag_q <= acc_q[0][AW-1] ? DPW'(-acc_q[0]) : DPW'(acc_q[0]);
						dneg_q <= acc_q[0][AW-1];
						drem_q <= '0; dq_q <= '0;
						cnt_q <= 6'd1;
					end else if (cnt_q <= 6'(ND)) begin
						dmag_q <= dmag_q << 16;
						dq_q <= {dq_q[DPW-17:0], dqd};
						drem_q <= ddiff[2:0];
						cnt_q <= cnt_q + 6'd1;
					end else begin
						// quotient toward zero; negative clamps to zero; saturate at 2^36
						for (int i = 0; i < 3; i++) acc_q[i] <= acc_q[i+1];
						acc_q[3] <= acc_q[0];
						thr_q[0] <= thr_q[1]; thr_q[1] <= thr_q[2]; thr_q[2] <= thr_q[3];
						if (dneg_q || dq_q == '0) thr_q[3] <= '0;
						else if (dq_q >= DPW'(THR_SAT)) thr_q[3] <= THR_SAT;
						else thr_q[3] <= 37'(dq_q);
						cnt_q <= '0;
						if (mot_cnt_q == 2'd3) ph_q <= PH_MAP;
					end
				end
				PH_MAP: begin
					pls_q[cnt_q[1:0]] <= pclip[11:0];
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3) ph_q <= PH_DONE;
				end
				PH_DONE: ph_q <= PH_IDLE;
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mot_cnt_q <= '0;
		else if (ph_q == PH_DIV && cnt_q == 6'(ND+1)) mot_cnt_q <= mot_cnt_q + 2'd1;
	end

	assign sts.done = (ph_q == PH_DONE);
	assign p_rr = pls_q[0];
	assign p_fr = pls_q[1];
	assign p_rl = pls_q[2];
	assign p_fl = pls_q[3];
endmodule

### hdl/qmm_ctrl.sv
// handshake controller and latched kill state
module qmm_ctrl import qmm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic kill,
	output logic out_valid,
	input  logic out_ready,
	output logic halted,
	output qmm_cmd_t cmd,
	input  qmm_sts_t sts
);
	`include "quad_motor_mixer_pwm_core_assert.svh"
	typedef enum logic [1:0] {S_IDLE, S_BUSY, S_OUT} st_t;
	st_t st_q;
	logic drive_on_q;
	logic kill_now;
	assign kill_now = kill | ~drive_on_q;
	assign in_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign cmd.start = in_valid && in_ready;
	assign cmd.halt = kill_now;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			drive_on_q <= 1'b1;
			halted <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (cmd.start) begin
					if (kill) drive_on_q <= 1'b0;
					halted <= kill_now;
					st_q <= S_BUSY;
				end
				S_BUSY: if (sts.done) st_q <= S_OUT;
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
	`QMM_ASSERT_IMP(a_halt_latched, !drive_on_q, halted || st_q == S_IDLE, "halt lost")
	`QMM_ASSERT_NEXT(a_off_stays, !drive_on_q, !drive_on_q, "drive re-enabled")
	`QMM_ASSERT_IMP(a_no_in_busy, st_q != S_IDLE, !in_ready, "accepted while busy")
endmodule

### hdl/quad_motor_mixer_pwm_core.sv
// top level of the quadrotor motor mixer with pulse outputs
//  channel | dir | fields
//  in      | in  | force_x force_y force_z yaw_cmd kill_line
//  out     | out | pulse_rear_right pulse_front_right pulse_rear_left pulse_front_left halted
//  cfg     | in  | index data
// one item at a time; each result passes the bitwise square root (VALUE_WIDTH+1 steps),
// sixteen multiply-accumulate steps and four divides by five (six steps each at
// VALUE_WIDTH 16)
// a new input waits until the last result is taken; a killed item skips the arithmetic
// reset restores config registers and enables drive; config always ready; result held until taken
module quad_motor_mixer_pwm_core import qmm_pkg::*; #(
	parameter int VALUE_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	qmm_in_if.sink in_ch,
	qmm_out_if.source out_ch,
	qmm_cfg_if.sink cfg
);
	logic [11:0] low_q, high_q, cap_q;
	logic [15:0] arml_q, armw_q;
	qmm_cmd_t cmd;
	qmm_sts_t sts;
	logic [11:0] p_rr, p_fr, p_rl, p_fl;
	logic halted;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= 12'd1000; high_q <= 12'd2000; cap_q <= 12'd1800;
			arml_q <= 16'd256; armw_q <= 16'd256;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_LOW: low_q <= cfg.data[11:0];
				REG_HIGH: high_q <= cfg.data[11:0];
				REG_CAP: cap_q <= cfg.data[11:0];
				REG_ARM_L: arml_q <= cfg.data;
				REG_ARM_W: armw_q <= cfg.data;
				default: ;
			endcase
		end
	end

	qmm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.kill(in_ch.kill_line), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.halted(halted), .cmd(cmd), .sts(sts)
	);

	qmm_datapath #(.W(VALUE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.fx_i(in_ch.force_x), .fy_i(in_ch.force_y), .fz_i(in_ch.force_z),
		.yw_i(in_ch.yaw_cmd), .low_q(low_q), .high_q(high_q), .cap_q(cap_q),
		.arml_q(arml_q), .armw_q(armw_q),
		.p_rr(p_rr), .p_fr(p_fr), .p_rl(p_rl), .p_fl(p_fl)
	);

	assign out_ch.pulse_rear_right = halted ? 12'd0 : p_rr;
	assign out_ch.pulse_front_right = halted ? 12'd0 : p_fr;
	assign out_ch.pulse_rear_left = halted ? 12'd0 : p_rl;
	assign out_ch.pulse_front_left = halted ? 12'd0 : p_fl;
	assign out_ch.halted = halted;
endmodule
